// ===== rtl/wrlbp_pkg.sv =====
// Package for the waveform run-length bit packer.
// Holds the coder state and result bundle types; no dependencies.
package wrlbp_pkg;

  localparam int WordW    = 32;
  localparam int SampleW  = 16;
  localparam int FillW    = 5;
  localparam int MaxWords = 3;
  localparam int CntW     = 2;

  typedef struct packed {
    logic [SampleW-1:0] held;
    logic               have;
    logic [SampleW-1:0] count;
    logic [WordW-1:0]   acc;
    logic [FillW-1:0]   fill;
  } state_t;

  typedef struct packed {
    logic [MaxWords-1:0][WordW-1:0] words;
    logic [MaxWords-1:0]            lasts;
    logic [CntW-1:0]                count;
  } bundle_t;

endpackage

// ===== rtl/wrlbp_coder.sv =====
// Combinational run tracking, code generation and word packing for one sample.
// Depends on wrlbp_pkg.
module wrlbp_coder #(
  parameter int VALUE_BITS = 10
) (
  input  logic [wrlbp_pkg::SampleW-1:0] sample_i,
  input  logic                          eow_i,
  input  wrlbp_pkg::state_t             state_i,
  output wrlbp_pkg::state_t             state_o,
  output wrlbp_pkg::bundle_t            bundle_o
);

  localparam int CodeW = VALUE_BITS + 1;
  localparam int StrW  = 128;
  localparam int PosW  = 7;

  logic               run_end;
  logic [15:0]        held_n;
  logic [15:0]        count_n;
  logic [StrW-1:0]    stream;
  logic [PosW-1:0]    pos0, pos1, pos2, pos3, pos4;
  logic [1:0]         nfull;
  logic [4:0]         rem;
  logic               capped;
  logic [1:0]         nout;
  logic               last_flag;

  function automatic logic [CodeW-1:0] code_bits(input logic [15:0] v);
    code_bits = (v == 16'd0) ? '0 : {v[VALUE_BITS-1:0], 1'b1};
  endfunction

  function automatic logic [PosW-1:0] code_len(input logic [15:0] v, input logic en);
    if (!en) code_len = '0;
    else if (v == 16'd0) code_len = PosW'(1);
    else code_len = PosW'(CodeW);
  endfunction

  function automatic logic [StrW-1:0] place(input logic [15:0] v, input logic en,
                                            input logic [PosW-1:0] p);
    place = en ? (StrW'(code_bits(v)) << p) : '0;
  endfunction

  always_comb begin
    run_end = state_i.have && (sample_i != state_i.held);
    if (!state_i.have || run_end) begin
      held_n  = sample_i;
      count_n = 16'd0;
    end else begin
      held_n  = state_i.held;
      count_n = state_i.count + 16'd1;
    end

    pos0 = {2'b00, state_i.fill};
    pos1 = pos0 + code_len(state_i.held, run_end);
    pos2 = pos1 + code_len(state_i.count, run_end);
    pos3 = pos2 + code_len(held_n, eow_i);
    pos4 = pos3 + code_len(count_n, eow_i);

    stream = {96'd0, state_i.acc}
           | place(state_i.held, run_end, pos0)
           | place(state_i.count, run_end, pos1)
           | place(held_n, eow_i, pos2)
           | place(count_n, eow_i, pos3);

    nfull  = pos4[6:5];
    rem    = pos4[4:0];
    capped = eow_i && (rem != 5'd0) && (nfull == 2'd3);
    if (eow_i && (rem != 5'd0)) begin
      nout = capped ? 2'd3 : nfull + 2'd1;
    end else begin
      nout = nfull;
    end
    last_flag = eow_i && !capped;

    for (int i = 0; i < wrlbp_pkg::MaxWords; i++) begin
      bundle_o.words[i] = stream[32*i +: 32];
      bundle_o.lasts[i] = last_flag && (nout == 2'(i + 1));
    end
    bundle_o.count = nout;

    if (eow_i) begin
      state_o = '0;
    end else begin
      state_o.held  = held_n;
      state_o.have  = 1'b1;
      state_o.count = count_n;
      state_o.fill  = rem;
      case (nfull)
        2'd0:    state_o.acc = stream[31:0];
        2'd1:    state_o.acc = stream[63:32];
        2'd2:    state_o.acc = stream[95:64];
        default: state_o.acc = stream[127:96];
      endcase
    end
  end

endmodule

// ===== rtl/wrlbp_out_buf.sv =====
// Result buffer: holds the words one sample produced and hands them out one per word.
// Depends on wrlbp_pkg.
module wrlbp_out_buf (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  wrlbp_pkg::bundle_t            bundle_i,
  output logic                          free_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [wrlbp_pkg::WordW-1:0]   packed_word_o,
  output logic                          last_word_o
);

  logic               valid_q, valid_d;
  logic [1:0]         idx_q, idx_d;
  wrlbp_pkg::bundle_t bund_q;
  logic               take, final_take;

  assign take       = valid_q && out_ready_i;
  assign final_take = take && (idx_q == bund_q.count - 2'd1);
  assign free_o     = !valid_q || final_take;

  assign out_valid_o   = valid_q;
  assign packed_word_o = bund_q.words[idx_q];
  assign last_word_o   = bund_q.lasts[idx_q];

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (load_i) begin
      valid_d = 1'b1;
      idx_d   = 2'd0;
    end else if (final_take) begin
      valid_d = 1'b0;
      idx_d   = 2'd0;
    end else if (take) begin
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bund_q <= bundle_i;
    end
  end

endmodule

// ===== rtl/waveform_run_length_bit_packer_top.sv =====
// Waveform run-length bit packer: input register, single-pass coder, result buffer.
// Depends on wrlbp_pkg, wrlbp_coder and wrlbp_out_buf.
//
// Accepts one sample per cycle while the input register is empty or its sample is
// coded, which waits for the result buffer to be free. Each taken sample is registered,
// then coded; its zero to three 32-bit words leave the result buffer one word per
// cycle while out_ready_i is high, and the next sample is not coded until the last of
// them is taken. Samples that close no word are not loaded into the buffer.
module waveform_run_length_bit_packer_top #(
  parameter int VALUE_BITS = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] sample_i,
  input  logic        end_of_waveform_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] packed_word_o,
  output logic        last_word_o
);

  logic               in_vld_q, in_vld_d;
  logic [15:0]        sample_q;
  logic               eow_q;
  wrlbp_pkg::state_t  state_q, state_d;
  wrlbp_pkg::bundle_t bundle;
  logic               buf_free;
  logic               fire;
  logic               load;

  assign fire       = in_vld_q && buf_free;
  assign load       = fire && (bundle.count != 2'd0);
  assign in_ready_o = !in_vld_q || fire;

  wrlbp_coder #(
    .VALUE_BITS(VALUE_BITS)
  ) u_coder (
    .sample_i (sample_q),
    .eow_i    (eow_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .bundle_o (bundle)
  );

  wrlbp_out_buf u_out_buf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (load),
    .bundle_i      (bundle),
    .free_o        (buf_free),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .packed_word_o (packed_word_o),
    .last_word_o   (last_word_o)
  );

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_valid_i && in_ready_o) in_vld_d = 1'b1;
    else if (fire) in_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      state_q  <= '0;
    end else begin
      in_vld_q <= in_vld_d;
      if (fire) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      sample_q <= sample_i;
      eow_q    <= end_of_waveform_i;
    end
  end

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for waveform_run_length_bit_packer_top.
// Needs wrlbp_pkg and the packer RTL; drives sample words, predicts packed words,
// and checks every output word in order.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WordW        = wrlbp_pkg::WordW;
  localparam int SampleW      = wrlbp_pkg::SampleW;
  localparam int VALUE_BITS   = 10;
  localparam int DIR_N        = 23;
  localparam int RANDOM_ITEMS = 205;
  localparam int QUIET_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 10;

  typedef struct packed {
    logic [WordW-1:0] word;
    logic             last;
  } packed_t;

  typedef struct packed {
    logic [SampleW-1:0] sample;
    logic               eow;
    logic               typed;
    logic [WordW-1:0]   word;
  } stim_row_t;

  logic               clk_i             = 1'b0;
  logic               rst_ni            = 1'b0;
  logic               in_valid_i        = 1'b0;
  logic [SampleW-1:0] sample_i          = '0;
  logic               end_of_waveform_i = 1'b0;
  logic               out_ready_i       = 1'b0;
  logic               in_ready_o;
  logic               out_valid_o;
  logic [WordW-1:0]   packed_word_o;
  logic               last_word_o;

  logic               calm = 1'b0;
  int                 mismatches = 0;
  int                 quiet_cycles = 0;
  packed_t            pending_words[$];
  packed_t            step_words[$];
  packed_t            head_word;
  stim_row_t          directed_rows[DIR_N];

  logic [SampleW-1:0] run_value;
  logic               run_open;
  logic [SampleW-1:0] run_repeats;
  logic [WordW-1:0]   word_bits;
  int                 word_fill;

  waveform_run_length_bit_packer_top #(
    .VALUE_BITS(VALUE_BITS)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .sample_i         (sample_i),
    .end_of_waveform_i(end_of_waveform_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .packed_word_o    (packed_word_o),
    .last_word_o      (last_word_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic void clear_packer();
    run_value   = '0;
    run_open    = 1'b0;
    run_repeats = '0;
    word_bits   = '0;
    word_fill   = 0;
  endfunction

  function automatic void shift_in_bit(input logic b);
    if (b) word_bits[word_fill] = 1'b1;
    word_fill++;
    if (word_fill == WordW) begin
      step_words.push_back('{word_bits, 1'b0});
      word_bits = '0;
      word_fill = 0;
    end
  endfunction

  function automatic void shift_in_code(input logic [SampleW-1:0] v);
    if (v == '0) begin
      shift_in_bit(1'b0);
    end else begin
      shift_in_bit(1'b1);
      for (int k = 0; k < VALUE_BITS; k++) shift_in_bit(v[k]);
    end
  endfunction

  function automatic void pack_sample(input logic [SampleW-1:0] s, input logic eow);
    packed_t tail;
    step_words.delete();
    if (!run_open) begin
      run_value   = s;
      run_repeats = '0;
      run_open    = 1'b1;
    end else if (s == run_value) begin
      run_repeats = run_repeats + 1'b1;
    end else begin
      shift_in_code(run_value);
      shift_in_code(run_repeats);
      run_value   = s;
      run_repeats = '0;
    end
    if (eow) begin
      shift_in_code(run_value);
      shift_in_code(run_repeats);
      if (word_fill > 0) begin
        step_words.push_back('{word_bits, 1'b1});
      end else if (step_words.size() > 0) begin
        tail = step_words.pop_back();
        tail.last = 1'b1;
        step_words.push_back(tail);
      end
      clear_packer();
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [WordW-1:0] got,
                                 input logic [WordW-1:0] want);
    $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $time);
    mismatches++;
  endtask

  // Call right after a rising edge; returns at the edge that takes the word.
  task automatic send_sample(input logic [SampleW-1:0] s, input logic eow,
                             input logic typed, input logic [WordW-1:0] typed_word);
    while (!calm && $urandom_range(0, 99) < 24) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    sample_i          <= s;
    end_of_waveform_i <= eow;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pack_sample(s, eow);
    if (typed) begin
      pending_words.push_back('{typed_word, 1'b1});
    end else begin
      foreach (step_words[i]) pending_words.push_back(step_words[i]);
    end
  endtask

  task automatic send_run(input logic [SampleW-1:0] v, input int copies, input logic eow);
    for (int i = 0; i < copies; i++) send_sample(v, eow && (i == copies - 1), 1'b0, '0);
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(0, 99) >= 24);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_words.size() == 0) begin
        report_mismatch("word with nothing pending", packed_word_o, '0);
      end else begin
        head_word = pending_words.pop_front();
        if (packed_word_o !== head_word.word)
          report_mismatch("packed_word", packed_word_o, head_word.word);
        if (last_word_o !== head_word.last)
          report_mismatch("last_word", {31'b0, last_word_o}, {31'b0, head_word.last});
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : stimulus
    logic [SampleW-1:0] v;
    logic [SampleW-1:0] prev;
    int                 random_items;
    int                 nruns;
    int                 copies;
    random_items = 0;
    prev = '0;
    clear_packer();
    // single-sample waveforms first, then waveforms made of runs
    directed_rows = '{
      '{16'h0000, 1'b1, 1'b1, 32'h0000_0000},
      '{16'hFFFF, 1'b1, 1'b1, 32'h0000_07FF},
      '{16'h0400, 1'b1, 1'b1, 32'h0000_0001},
      '{16'h0001, 1'b1, 1'b1, 32'h0000_0003},
      '{16'h8000, 1'b1, 1'b1, 32'h0000_0001},
      '{16'h03FF, 1'b1, 1'b1, 32'h0000_07FF},
      '{16'h1234, 1'b0, 1'b0, 32'h0},
      '{16'h1234, 1'b0, 1'b0, 32'h0},
      '{16'h1234, 1'b0, 1'b0, 32'h0},
      '{16'hABCD, 1'b0, 1'b0, 32'h0},
      '{16'h0000, 1'b0, 1'b0, 32'h0},
      '{16'h0000, 1'b0, 1'b0, 32'h0},
      '{16'hABCD, 1'b1, 1'b0, 32'h0},
      '{16'h0000, 1'b0, 1'b0, 32'h0},
      '{16'h0005, 1'b0, 1'b0, 32'h0},
      '{16'h0005, 1'b0, 1'b0, 32'h0},
      '{16'h0000, 1'b0, 1'b0, 32'h0},
      '{16'h0005, 1'b0, 1'b0, 32'h0},
      '{16'h0005, 1'b0, 1'b0, 32'h0},
      '{16'h0000, 1'b0, 1'b0, 32'h0},
      '{16'h0007, 1'b0, 1'b0, 32'h0},
      '{16'h0000, 1'b0, 1'b0, 32'h0},
      '{16'h0000, 1'b1, 1'b0, 32'h0}
    };
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_sample(directed_rows[i].sample, directed_rows[i].eow,
                  directed_rows[i].typed, directed_rows[i].word);

    // longer runs: one closed by a new value, one closed by the end of the waveform
    send_run(16'h0155, 12, 1'b0);
    send_run(16'h0156, 9, 1'b1);

    while (random_items < RANDOM_ITEMS) begin
      nruns = $urandom_range(1, 6);
      for (int r = 0; r < nruns; r++) begin
        case ($urandom_range(0, 5))
          0: v = '0;
          1: v = SampleW'($urandom_range(0, 65535));
          2: v = SampleW'($urandom_range(0, 1023));
          3: v = SampleW'($urandom_range(0, 63)) << VALUE_BITS;
          4: v = prev ^ (SampleW'(1) << $urandom_range(VALUE_BITS, SampleW - 1));
          default: v = $urandom_range(0, 1) ? 16'hFFFF : 16'h0001;
        endcase
        copies = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 4);
        for (int c = 0; c < copies; c++) begin
          calm = (random_items >= 90) && (random_items < 170);
          send_sample(v, (r == nruns - 1) && (c == copies - 1), 1'b0, '0);
          random_items++;
        end
        prev = v;
      end
    end
    in_valid_i <= 1'b0;
    calm = 1'b0;

    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
